FILE: rtl/core/iqf_pkg.sv
package iqf_pkg;

    // Default queue depth, in entries
    localparam int DEFAULT_DEPTH = 256;

    localparam int MSG_W   = 16;
    localparam int HND_W   = 16;
    localparam int ENTRY_W = MSG_W + HND_W;
    localparam int ICNT_W  = 32;
    localparam int ECNT_W  = 9;

    // Request codes
    localparam logic [2:0] REQ_PUSH   = 3'd0;
    localparam logic [2:0] REQ_POP    = 3'd1;
    localparam logic [2:0] REQ_Q_ON   = 3'd2;
    localparam logic [2:0] REQ_Q_OFF  = 3'd3;
    localparam logic [2:0] REQ_CHECK  = 3'd4;
    localparam logic [2:0] REQ_SETLST = 3'd5;
    localparam logic [2:0] REQ_DROP   = 3'd6;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    typedef struct packed {
        logic [2:0]        req_type;
        logic [MSG_W-1:0]  int_message;
        logic [HND_W-1:0]  handler_addr;
        logic [ICNT_W-1:0] instr_count;
    } t_in;

    typedef struct packed {
        logic [MSG_W-1:0]  out_message;
        logic [HND_W-1:0]  out_handler;
        logic [1:0]        status;
        logic              dispatch_ready;
        logic              queueing_flag;
        logic [ECNT_W-1:0] entry_count;
    } t_out;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic execute;
    } t_cmd;

endpackage

FILE: rtl/core/iqf_ctrl.sv
module iqf_ctrl
    import iqf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_OUT
    } t_state;

    t_state r_state;
    logic   r_in_ready;
    logic   r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state    <= S_EXEC;
                        r_in_ready <= 1'b0;
                    end
                end
                S_EXEC: begin
                    r_state     <= S_OUT;
                    r_out_valid <= 1'b1;
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        r_state     <= S_IDLE;
                        r_out_valid <= 1'b0;
                        r_in_ready  <= 1'b1;
                    end
                end
                default: begin
                    r_state     <= S_IDLE;
                    r_out_valid <= 1'b0;
                    r_in_ready  <= 1'b1;
                end
            endcase
        end
    end

    assign o_in_ready    = r_in_ready;
    assign o_out_valid   = r_out_valid;
    assign o_cmd.capture = r_in_ready && i_in_valid;
    assign o_cmd.execute = (r_state == S_EXEC);

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("iqf_ctrl: input and output open together");

    a_cap_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> o_cmd.execute)
        else $error("iqf_ctrl: capture not followed by execute");

    a_exec_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.execute |=> (o_out_valid && !o_cmd.execute))
        else $error("iqf_ctrl: execute not followed by result");
`endif

endmodule

FILE: rtl/core/iqf_dp.sv
module iqf_dp
    import iqf_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    input  t_in  i_in_data,
    output t_out o_out_data
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(QUEUE_DEPTH);

    logic [ENTRY_W-1:0] r_mem [QUEUE_DEPTH];

    t_in                r_item;
    logic [AW-1:0]      r_head, n_head;
    logic [AW-1:0]      r_tail, n_tail;
    logic [CW-1:0]      r_count, n_count;
    logic               r_qon, n_qon;
    logic [ICNT_W-1:0]  r_last, n_last;
    logic [ENTRY_W-1:0] r_rd;
    logic               r_pop_ok, n_pop_ok;
    logic               n_push_ok;
    logic [1:0]         r_status, n_status;
    logic               r_disp, n_disp;
    logic [ECNT_W-1:0]  r_ecnt;
    logic               r_qflag;
    logic [ICNT_W-1:0]  gap;
    logic [CW+ECNT_W-1:0] cnt_ext;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in_data;
        end
    end

    assign gap = r_item.instr_count - r_last;

    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_qon     = r_qon;
        n_last    = r_last;
        n_pop_ok  = 1'b0;
        n_push_ok = 1'b0;
        n_status  = ST_OK;
        n_disp    = 1'b0;
        case (r_item.req_type)
            REQ_PUSH: begin
                if (r_count < FULL_CNT) begin
                    n_push_ok = 1'b1;
                    n_tail    = (r_tail == LAST_SLOT) ? '0 : r_tail + AW'(1);
                    n_count   = r_count + CW'(1);
                end else begin
                    n_status = ST_OVERFLOW;
                end
            end
            REQ_POP: begin
                if (r_count == '0) begin
                    n_status = ST_UNDERFLOW;
                end else begin
                    n_pop_ok = 1'b1;
                    n_head   = (r_head == LAST_SLOT) ? '0 : r_head + AW'(1);
                    n_count  = r_count - CW'(1);
                end
            end
            REQ_Q_ON:   n_qon  = 1'b1;
            REQ_Q_OFF:  n_qon  = 1'b0;
            REQ_CHECK:  n_disp = !r_qon && (r_count != '0) && (gap > ICNT_W'(1));
            REQ_SETLST: n_last = r_item.instr_count;
            REQ_DROP: begin
                n_head  = '0;
                n_tail  = '0;
                n_count = '0;
            end
            default: ;
        endcase
    end

    assign cnt_ext = (CW + ECNT_W)'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_qon   <= 1'b0;
            r_last  <= '0;
        end else if (i_cmd.execute) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_qon   <= n_qon;
            r_last  <= n_last;
        end
    end

    // Result register, held until the next item executes
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            r_pop_ok <= n_pop_ok;
            r_status <= n_status;
            r_disp   <= n_disp;
            r_qflag  <= n_qon;
            r_ecnt   <= cnt_ext[ECNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute && n_push_ok) begin
            r_mem[r_tail] <= {r_item.int_message, r_item.handler_addr};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute && n_pop_ok) begin
            r_rd <= r_mem[r_head];
        end
    end

    assign o_out_data.out_message    = r_pop_ok ? r_rd[ENTRY_W-1:HND_W] : '0;
    assign o_out_data.out_handler    = r_pop_ok ? r_rd[HND_W-1:0] : '0;
    assign o_out_data.status         = r_status;
    assign o_out_data.dispatch_ready = r_disp;
    assign o_out_data.queueing_flag  = r_qflag;
    assign o_out_data.entry_count    = r_ecnt;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("iqf_dp: entry count beyond depth");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_head == r_tail))
        else $error("iqf_dp: empty queue with misaligned pointers");

    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.execute && r_item.req_type == REQ_DROP) |=>
            (r_count == '0 && r_head == '0 && r_tail == '0))
        else $error("iqf_dp: drop left entries behind");
`endif

endmodule

FILE: rtl/core/interrupt_queue_fifo_core.sv
// Interrupt queue: a circular FIFO of (message, handler address) pairs
// with a queueing flag and the instruction count of the last interrupt.
// Input channel (i_in_valid / o_in_ready / i_in_data) carries one request
// beat: push, pop, queueing on/off, dispatch check, set last count, drop.
// Every request gives exactly one result beat on the output channel
// (o_out_valid / i_out_ready / o_out_data).
// A request is captured when accepted, executed in the execute state, and
// its result is registered there and presented in the result state.
// The controller handles one request at a time (capture, execute with at
// most one entry memory access, present result).
// A stalled receiver holds the result beat steady and the input stays
// closed until the beat is taken.
// Reset (i_rst_n low, synchronous) empties the queue, clears the queueing
// flag and the last count; entry memory contents are not cleared and need
// no clearing pass, since only written slots are ever popped.
module interrupt_queue_fifo_core
    import iqf_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    t_cmd cmd;

    // Sequencer: idle -> execute -> result
    iqf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    // Pointers, count, flag, last count, entry memory and result register
    iqf_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_data  (i_in_data),
        .o_out_data (o_out_data)
    );

endmodule
